// ===== hdl/rmp_pkg.sv =====
// Shared types and constants of the ROI max pooling block.
package rmp_pkg;

    localparam int CORNER_W = 13;
    localparam int SIZE_W = 13;
    localparam int DIV_W = 16;

    localparam logic [2:0] REG_SCALE = 3'd0;
    localparam logic [2:0] REG_PROWS = 3'd1;
    localparam logic [2:0] REG_PCOLS = 3'd2;
    localparam logic [2:0] REG_CHANS = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;
    localparam logic [2:0] REG_WIDTH = 3'd5;
    localparam logic [2:0] REG_BATCH = 3'd6;

    localparam logic [1:0] DSEL_SPAN_H = 2'd0;
    localparam logic [1:0] DSEL_SPAN_W = 2'd1;
    localparam logic [1:0] DSEL_OFF_H = 2'd2;
    localparam logic [1:0] DSEL_OFF_W = 2'd3;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       size;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_save;
        logic       clip;
        logic       scan;
        logic       emit;
        logic       next_bin;
    } rmp_cmd_t;

    typedef struct packed {
        logic pool_req;
        logic mul_last;
        logic div_done;
        logic scan_done;
        logic out_free;
        logic new_row;
        logic last_bin;
    } rmp_stat_t;

endpackage

// ===== hdl/rmp_div.sv =====
// Restoring divider, one quotient bit per cycle, for small divisors.
module rmp_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [rmp_pkg::DIV_W-1:0] num,
    input  logic [3:0]               den,
    output logic                     done,
    output logic [rmp_pkg::DIV_W-1:0] quo
);
    import rmp_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg, q_next;
    logic [3:0]       rem_reg, rem_next;
    logic [3:0]       den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       trial;

    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, q_reg[DIV_W-1]};
        if (start)
        begin
            q_next = num;
            rem_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 4'(trial - {1'b0, den_reg});
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[3:0];
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo = q_reg;

endmodule

// ===== hdl/rmp_datapath.sv =====
// Datapath: configuration, feature store, corner scaling, bin bounds and max search.
module rmp_datapath #(
    parameter int MAX_BATCH = 2,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_HEIGHT = 32,
    parameter int MAX_WIDTH = 32,
    parameter int MAX_POOLED = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rmp_pkg::rmp_cmd_t  cmd,
    output rmp_pkg::rmp_stat_t stat,
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               req_type,
    input  logic [14:0]        feat_addr,
    input  logic signed [15:0] feat_value,
    input  logic               roi_batch,
    input  logic [3:0]         roi_channel,
    input  logic [15:0]        roi_x1,
    input  logic [15:0]        roi_y1,
    input  logic [15:0]        roi_x2,
    input  logic [15:0]        roi_y2,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         bin_row,
    output logic [2:0]         bin_col,
    output logic signed [15:0] pooled_value,
    output logic signed [10:0] argmax_index,
    output logic               last_bin,
    output logic               bad_request
);
    import rmp_pkg::*;

    localparam int DEPTH = MAX_BATCH * MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_HI = (MAX_CHANNELS > 31) ? 31 : MAX_CHANNELS;
    localparam int HT_HI = (MAX_HEIGHT > 63) ? 63 : MAX_HEIGHT;
    localparam int WD_HI = (MAX_WIDTH > 63) ? 63 : MAX_WIDTH;
    localparam int PL_HI = (MAX_POOLED > 8) ? 8 : MAX_POOLED;
    localparam int NB_HI = (MAX_BATCH > 3) ? 3 : MAX_BATCH;

    logic [15:0] scale_reg;
    logic [3:0]  prows_reg, pcols_reg;
    logic [4:0]  chans_reg;
    logic [5:0]  height_reg, width_reg;
    logic [1:0]  batch_cnt_reg;

    logic [3:0] prow, pcol;
    logic [4:0] chans;
    logic [5:0] hgt, wid;
    logic [1:0] nb;

    logic [15:0] feature_store [DEPTH];

    logic          batch_reg;
    logic [3:0]    chan_reg;
    logic [15:0]   corner_in_reg [4];
    logic          bad_reg, skip_reg;
    logic [1:0]    mul_idx_reg;
    logic [CORNER_W-1:0] corner_reg [4];
    logic [SIZE_W-1:0]   rw_reg, rh_reg;
    logic [DIV_W-1:0]    span_h_reg, span_w_reg, off_h_reg, off_w_reg;
    logic [1:0]    div_sel_reg;
    logic [5:0]    p1_reg;
    logic [11:0]   p2_reg;
    logic [17:0]   p3_reg;
    logic [2:0]    ph_reg, pw_reg;
    logic [5:0]    h_reg, w_reg, ws_reg, he_reg, we_reg;
    logic          issue_reg, v1_reg, v2_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [11:0]   local1_reg, local2_reg;
    logic [15:0]   rd_reg;
    logic          found_reg;
    logic signed [15:0] best_reg;
    logic [10:0]   best_idx_reg;
    logic          out_valid_reg;

    logic [32:0]  prod;
    logic [15:0]  corner_sel;
    logic [DIV_W-1:0] div_num, div_quo;
    logic [3:0]   div_den;
    logic         div_done;
    logic [14:0]  hs_full, ws_full;
    logic [15:0]  he_full, we_full;
    logic [5:0]   hs_c, ws_c, he_c, we_c;
    logic [11:0]  local_now;
    logic [31:0]  addr_sum;

    assign prow = (prows_reg == 4'd0) ? 4'd1 : (prows_reg > 4'(PL_HI)) ? 4'(PL_HI) : prows_reg;
    assign pcol = (pcols_reg == 4'd0) ? 4'd1 : (pcols_reg > 4'(PL_HI)) ? 4'(PL_HI) : pcols_reg;
    assign chans = (chans_reg == 5'd0) ? 5'd1 : (chans_reg > 5'(CH_HI)) ? 5'(CH_HI) : chans_reg;
    assign hgt = (height_reg == 6'd0) ? 6'd1 : (height_reg > 6'(HT_HI)) ? 6'(HT_HI) : height_reg;
    assign wid = (width_reg == 6'd0) ? 6'd1 : (width_reg > 6'(WD_HI)) ? 6'(WD_HI) : width_reg;
    assign nb = (batch_cnt_reg > 2'(NB_HI)) ? 2'(NB_HI) : batch_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 16'd4096;
            prows_reg <= 4'd7;
            pcols_reg <= 4'd7;
            chans_reg <= 5'd16;
            height_reg <= 6'd32;
            width_reg <= 6'd32;
            batch_cnt_reg <= 2'd2;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_SCALE:  scale_reg <= cfg_data;
                REG_PROWS:  prows_reg <= cfg_data[3:0];
                REG_PCOLS:  pcols_reg <= cfg_data[3:0];
                REG_CHANS:  chans_reg <= cfg_data[4:0];
                REG_HEIGHT: height_reg <= cfg_data[5:0];
                REG_WIDTH:  width_reg <= cfg_data[5:0];
                REG_BATCH:  batch_cnt_reg <= cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    // Feature store: writes arrive only while idle, reads only during a scan.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall && !req_type && (32'(feat_addr) < DEPTH))
        begin
            feature_store[feat_addr[ADDR_W-1:0]] <= feat_value;
        end
        if (v1_reg)
        begin
            rd_reg <= feature_store[addr_reg];
        end
    end

    assign corner_sel = corner_in_reg[mul_idx_reg];
    assign prod = 33'(corner_sel * scale_reg) + 33'(1 << 19);

    always_comb
    begin
        unique case (cmd.div_sel)
            DSEL_SPAN_H: begin div_num = 16'(rh_reg) + 16'(prow) - 16'd1; div_den = prow; end
            DSEL_SPAN_W: begin div_num = 16'(rw_reg) + 16'(pcol) - 16'd1; div_den = pcol; end
            DSEL_OFF_H:  begin div_num = 16'(ph_reg * rh_reg); div_den = prow; end
            default:     begin div_num = 16'(pw_reg * rw_reg); div_den = pcol; end
        endcase
    end

    rmp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign hs_full = 15'(corner_reg[1]) + 15'(off_h_reg);
    assign ws_full = 15'(corner_reg[0]) + 15'(off_w_reg);
    assign he_full = 16'(hs_full) + span_h_reg;
    assign we_full = 16'(ws_full) + span_w_reg;
    assign hs_c = (hs_full > 15'(hgt)) ? hgt : hs_full[5:0];
    assign ws_c = (ws_full > 15'(wid)) ? wid : ws_full[5:0];
    assign he_c = (he_full > 16'(hgt)) ? hgt : he_full[5:0];
    assign we_c = (we_full > 16'(wid)) ? wid : we_full[5:0];
    assign local_now = 12'(h_reg * wid) + 12'(w_reg);
    assign addr_sum = 32'(p3_reg) + 32'(local_now);

    always_ff @(posedge clk)
    begin
        p1_reg <= 6'(batch_reg * chans) + 6'(chan_reg);
        p2_reg <= 12'(p1_reg * hgt);
        p3_reg <= 18'(p2_reg * wid);
        local2_reg <= local1_reg;
        if (cmd.load)
        begin
            batch_reg <= roi_batch;
            chan_reg <= roi_channel;
            corner_in_reg[0] <= roi_x1;
            corner_in_reg[1] <= roi_y1;
            corner_in_reg[2] <= roi_x2;
            corner_in_reg[3] <= roi_y2;
            bad_reg <= {1'b0, roi_batch} >= nb;
            skip_reg <= ({1'b0, roi_batch} >= nb) || ({1'b0, roi_channel} >= chans);
        end
        if (cmd.mul)
        begin
            corner_reg[mul_idx_reg] <= prod[32:20];
        end
        if (cmd.size)
        begin
            rw_reg <= (corner_reg[2] >= corner_reg[0]) ?
                      corner_reg[2] - corner_reg[0] + 1'b1 : SIZE_W'(1);
            rh_reg <= (corner_reg[3] >= corner_reg[1]) ?
                      corner_reg[3] - corner_reg[1] + 1'b1 : SIZE_W'(1);
        end
        if (cmd.div_save)
        begin
            unique case (div_sel_reg)
                DSEL_SPAN_H: span_h_reg <= div_quo;
                DSEL_SPAN_W: span_w_reg <= div_quo;
                DSEL_OFF_H:  off_h_reg <= div_quo;
                default:     off_w_reg <= div_quo;
            endcase
        end
        if (cmd.clip)
        begin
            h_reg <= hs_c;
            w_reg <= ws_c;
            ws_reg <= ws_c;
            he_reg <= he_c;
            we_reg <= we_c;
        end
        else if (cmd.scan && issue_reg)
        begin
            addr_reg <= addr_sum[ADDR_W-1:0];
            local1_reg <= local_now;
            if (w_reg + 1'b1 == we_reg)
            begin
                w_reg <= ws_reg;
                h_reg <= h_reg + 1'b1;
            end
            else
            begin
                w_reg <= w_reg + 1'b1;
            end
        end
        if (v2_reg && (!found_reg || $signed(rd_reg) > best_reg))
        begin
            best_reg <= $signed(rd_reg);
            best_idx_reg <= local2_reg[10:0];
        end
        if (cmd.emit)
        begin
            bin_row <= ph_reg;
            bin_col <= pw_reg;
            pooled_value <= found_reg ? best_reg : 16'sd0;
            argmax_index <= found_reg ? $signed(best_idx_reg) : -11'sd1;
            last_bin <= stat.last_bin;
            bad_request <= bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_idx_reg <= '0;
            div_sel_reg <= DSEL_SPAN_H;
            ph_reg <= '0;
            pw_reg <= '0;
            issue_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
            v1_reg <= cmd.scan && issue_reg;
            if (cmd.load)
            begin
                mul_idx_reg <= '0;
                ph_reg <= '0;
                pw_reg <= '0;
            end
            else if (cmd.mul)
            begin
                mul_idx_reg <= mul_idx_reg + 1'b1;
            end
            if (cmd.div_start)
            begin
                div_sel_reg <= cmd.div_sel;
            end
            if (cmd.clip)
            begin
                issue_reg <= !skip_reg && (hs_c < he_c) && (ws_c < we_c);
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan && issue_reg && (w_reg + 1'b1 == we_reg) &&
                    (h_reg + 1'b1 == he_reg))
                begin
                    issue_reg <= 1'b0;
                end
                if (v2_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.next_bin)
            begin
                if (stat.new_row)
                begin
                    pw_reg <= '0;
                    ph_reg <= ph_reg + 1'b1;
                end
                else
                begin
                    pw_reg <= pw_reg + 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    assign stat.pool_req = req_type;
    assign stat.mul_last = (mul_idx_reg == 2'd3);
    assign stat.div_done = div_done;
    assign stat.scan_done = !issue_reg && !v1_reg && !v2_reg;
    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.new_row = ({1'b0, pw_reg} == pcol - 1'b1);
    assign stat.last_bin = ({1'b0, pw_reg} == pcol - 1'b1) && ({1'b0, ph_reg} == prow - 1'b1);

endmodule

// ===== hdl/rmp_ctrl.sv =====
// Controller state machine that sequences each pool request.
module rmp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rmp_pkg::rmp_stat_t stat,
    output rmp_pkg::rmp_cmd_t  cmd
);
    import rmp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SIZE  = 4'd2;
    localparam logic [3:0] S_START = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_CLIP  = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;

    logic [3:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next = sel_reg;
        cmd = '0;
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && stat.pool_req)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                cmd.size = 1'b1;
                sel_next = DSEL_SPAN_H;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_save = 1'b1;
                    if (sel_reg == DSEL_OFF_W)
                    begin
                        state_next = S_CLIP;
                    end
                    else
                    begin
                        sel_next = sel_reg + 1'b1;
                        state_next = S_START;
                    end
                end
            end
            S_CLIP:
            begin
                cmd.clip = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_bin)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_bin = 1'b1;
                        sel_next = stat.new_row ? DSEL_OFF_H : DSEL_OFF_W;
                        state_next = S_START;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg <= DSEL_SPAN_H;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg <= sel_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== hdl/roi_max_pool_forward_top.sv =====
// Top level of the ROI max pooling block.
// Feature writes may follow each other in every cycle while the block is idle.
// A pool request loads and scales the four corners and sizes the region, then divides
// by the bin count in the serial divider (two divisions for the spans at the start,
// one per bin and a second on the first bin of each row); for every bin it clips the
// bounds, scans each covered map cell through the single read port of the feature
// store, drains the store read and hands the bin on once the output register is free.
// Bins leave through an output register, and a new request is accepted once the last
// bin of the previous one is registered there.
module roi_max_pool_forward_top #(
    parameter int MAX_BATCH = 2,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_HEIGHT = 32,
    parameter int MAX_WIDTH = 32,
    parameter int MAX_POOLED = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [14:0]        feat_addr,
    input  logic signed [15:0] feat_value,
    input  logic               roi_batch,
    input  logic [3:0]         roi_channel,
    input  logic [15:0]        roi_x1,
    input  logic [15:0]        roi_y1,
    input  logic [15:0]        roi_x2,
    input  logic [15:0]        roi_y2,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         bin_row,
    output logic [2:0]         bin_col,
    output logic signed [15:0] pooled_value,
    output logic signed [10:0] argmax_index,
    output logic               last_bin,
    output logic               bad_request
);
    import rmp_pkg::*;

    rmp_cmd_t  cmd;
    rmp_stat_t stat;

    rmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    rmp_datapath #(
        .MAX_BATCH    (MAX_BATCH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_POOLED   (MAX_POOLED)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .feat_addr    (feat_addr),
        .feat_value   (feat_value),
        .roi_batch    (roi_batch),
        .roi_channel  (roi_channel),
        .roi_x1       (roi_x1),
        .roi_y1       (roi_y1),
        .roi_x2       (roi_x2),
        .roi_y2       (roi_y2),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bin_row      (bin_row),
        .bin_col      (bin_col),
        .pooled_value (pooled_value),
        .argmax_index (argmax_index),
        .last_bin     (last_bin),
        .bad_request  (bad_request)
    );

endmodule
